// ----- hdl/olid_pkg.sv -----
package olid_pkg;

    localparam int VAL_W = 32;
    localparam int LEN_W = 7;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DEL_HEAD = 2'd1,
        CMD_DEL_TAIL = 2'd2,
        CMD_DEL_KEY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic match;
        logic remove;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_key;
    } t_dp_sts;

endpackage

// ----- hdl/olid_if.sv -----
interface olid_req_if;
    import olid_pkg::*;

    logic                    valid;
    logic                    ready;
    t_cmd                    command;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

interface olid_rsp_if;
    import olid_pkg::*;

    logic             valid;
    logic             ready;
    t_status          status;
    logic [LEN_W-1:0] length;

    modport source (output valid, status, length, input ready);
    modport sink   (input valid, status, length, output ready);
endinterface

// ----- hdl/olid_dp.sv -----
module olid_dp #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  olid_pkg::t_dp_cmd                i_cmd,
    output olid_pkg::t_dp_sts                o_sts,
    input  olid_pkg::t_cmd                   i_command,
    input  logic signed [olid_pkg::VAL_W-1:0] i_value,
    output olid_pkg::t_status                o_status,
    output logic [olid_pkg::LEN_W-1:0]       o_length
);
    import olid_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_cmd                    r_cmd;
    logic signed [VAL_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_cells [DEPTH];
    logic [CW-1:0]           r_count, n_count;
    logic [DEPTH-1:0]        r_match, n_match;
    logic [DEPTH-1:0]        r_below, n_below;
    t_status                 r_status, n_status;
    t_status                 r_out_status;
    logic [CW-1:0]           r_out_count;

    logic             full;
    logic             empty;
    logic             wr_en;
    logic             shift_en;
    logic [DEPTH-1:0] keep;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // every cell compares against the key at once
    for (genvar i = 0; i < DEPTH; i++) begin : g_match
        assign n_match[i] = (r_cells[i] == r_key) && (CW'(i) < r_count);
    end

    // cells strictly ahead of the first match stay put
    assign n_below = ~n_match & (n_match - DEPTH'(1));

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        wr_en    = 1'b0;
        shift_en = 1'b0;
        keep     = r_below;
        if (i_cmd.exec) begin
            unique case (r_cmd)
                CMD_INSERT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        n_count  = r_count + CW'(1);
                        n_status = ST_OK;
                    end
                end
                CMD_DEL_HEAD: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        shift_en = 1'b1;
                        keep     = '0;
                        n_count  = r_count - CW'(1);
                        n_status = ST_OK;
                    end
                end
                CMD_DEL_TAIL: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count  = r_count - CW'(1);
                        n_status = ST_OK;
                    end
                end
                CMD_DEL_KEY: begin
                    n_status = r_status;
                end
            endcase
        end else if (i_cmd.remove) begin
            if (|r_match) begin
                shift_en = 1'b1;
                n_count  = r_count - CW'(1);
                n_status = ST_OK;
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i < DEPTH - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (wr_en && (r_count == CW'(i))) begin
                    r_cells[i] <= r_key;
                end else if (shift_en && !keep[i]) begin
                    r_cells[i] <= r_cells[i+1];
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (wr_en && (r_count == CW'(i))) begin
                    r_cells[i] <= r_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.latch) begin
            r_cmd <= i_command;
            r_key <= i_value;
        end
        if (i_cmd.match) begin
            r_match <= n_match;
            r_below <= n_below;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_sts.is_key = (r_cmd == CMD_DEL_KEY);
    assign o_status     = r_out_status;
    assign o_length     = LEN_W'(r_out_count);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.remove && (|r_match) |=> r_count == $past(r_count) - CW'(1))
        else $error("key removal did not shorten the list");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (r_cmd == CMD_INSERT) && full
        |=> (r_count == CW'(DEPTH)) && (r_status == ST_FULL))
        else $error("insert into full list not dropped");

endmodule

// ----- hdl/olid_ctrl.sv -----
module olid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output olid_pkg::t_dp_cmd o_cmd,
    input  olid_pkg::t_dp_sts i_sts
);
    import olid_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.is_key) begin
                    o_cmd.match = 1'b1;
                    n_state     = S_SHIFT;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.remove = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // wait here while the previous result is still unclaimed
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside completion");

endmodule

// ----- hdl/ordered_list_insert_delete.sv -----
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells,
// head in cell 0. A request carries a command (insert at tail, delete head,
// delete tail, delete first entry equal to value) and returns one result with
// a status and the length afterwards. Insert on a full list is dropped with
// status full; deletes on an empty list report empty, and a key delete with
// no match reports not found. One request is worked at a time: insert and
// the two plain deletes are latched, executed and then loaded as the result;
// delete by key adds a shift step, as all cells are compared at once and
// the first-match mask is registered before the cells close up after it.
// The result sits in an output register, so a new request is taken while it
// waits; a further result holds the controller until the register is free.
module ordered_list_insert_delete #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olid_req_if.sink   i_req,
    olid_rsp_if.source o_rsp
);
    import olid_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    olid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    olid_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .i_command (i_req.command),
        .i_value   (i_req.value),
        .o_status  (o_rsp.status),
        .o_length  (o_rsp.length)
    );

endmodule

// ----- bench/tb.sv -----
module tb;
    import olid_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct {
        t_status          status;
        logic [LEN_W-1:0] length;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    olid_req_if req_if ();
    olid_rsp_if rsp_if ();

    ordered_list_insert_delete #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predicted list contents, head first
    logic signed [VAL_W-1:0] list_model[$];
    t_list_result            pending_results[$];

    int errors      = 0;
    int sent_cnt    = 0;
    int result_cnt  = 0;
    int cycle_cnt   = 0;
    int status_hits[4];
    bit idle_on     = 1'b1;
    int hold_req    = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void list_apply_command(t_cmd cmd, logic signed [VAL_W-1:0] val);
        t_list_result r;
        int           pos;
        r.status = ST_OK;
        pos      = -1;
        case (cmd)
            CMD_INSERT: begin
                if (list_model.size() >= DEPTH) r.status = ST_FULL;
                else list_model.push_back(val);
            end
            CMD_DEL_HEAD: begin
                if (list_model.size() == 0) r.status = ST_EMPTY;
                else void'(list_model.pop_front());
            end
            CMD_DEL_TAIL: begin
                if (list_model.size() == 0) r.status = ST_EMPTY;
                else void'(list_model.pop_back());
            end
            default: begin
                // first match nearest the head
                for (int i = 0; i < list_model.size(); i++)
                    if (pos < 0 && list_model[i] == val) pos = i;
                if (pos < 0) r.status = ST_NOT_FOUND;
                else list_model.delete(pos);
            end
        endcase
        r.length = LEN_W'(list_model.size());
        pending_results.push_back(r);
    endfunction

    function automatic void check_result(t_status st, logic [LEN_W-1:0] len);
        t_list_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, status %0d length %0d", $time, st, len);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        result_cnt++;
        status_hits[want.status]++;
        if (st !== want.status) begin
            $display("%0t: status mismatch, expected %s actual %0d",
                     $time, want.status.name(), st);
            errors++;
        end
        if (len !== want.length) begin
            $display("%0t: length mismatch, expected %0d actual %0d",
                     $time, want.length, len);
            errors++;
        end
    endfunction

    // both handshakes observed on the edge itself, before any update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                list_apply_command(req_if.command, req_if.value);
            if (rsp_if.valid && rsp_if.ready)
                check_result(rsp_if.status, rsp_if.length);
        end
    end

    // result side: per-result stall plus an occasional long hold-off
    initial begin : rsp_side
        int   wait_left;
        int   hold_left;
        logic took;
        wait_left    = 0;
        hold_left    = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            took = rsp_if.valid && rsp_if.ready;
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            @(negedge i_clk);
            if (took) wait_left = idle_on ? $urandom_range(0, 3) : 0;
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (wait_left > 0) begin
                rsp_if.ready <= 1'b0;
                wait_left--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input t_cmd cmd, input logic signed [VAL_W-1:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= cmd;
        req_if.value   <= val;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_cnt++;
    endtask

    task automatic wait_until_drained();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return VAL_W'($urandom_range(0, 7));
        if (roll < 45) return VAL_MIN;
        if (roll < 50) return VAL_MAX;
        if (roll < 55) return -1;
        return $urandom;
    endfunction

    // list state is current here: the previous request has been accepted
    task automatic send_random_request(input int insert_pct);
        int                      roll;
        t_cmd                    cmd;
        logic signed [VAL_W-1:0] val;
        roll = $urandom_range(0, 99);
        val  = pick_value();
        if (roll < insert_pct) begin
            cmd = CMD_INSERT;
        end else begin
            case ($urandom_range(0, 3))
                0:       cmd = CMD_DEL_HEAD;
                1:       cmd = CMD_DEL_TAIL;
                default: cmd = CMD_DEL_KEY;
            endcase
            // mostly keys that are present, so matches land anywhere in the list
            if (cmd == CMD_DEL_KEY && list_model.size() > 0 && $urandom_range(0, 3) != 0)
                val = list_model[$urandom_range(0, list_model.size() - 1)];
        end
        send_request(cmd, val);
    endtask

    task automatic test_empty_list();
        send_request(CMD_DEL_HEAD, 0);
        send_request(CMD_DEL_TAIL, -1);
        send_request(CMD_DEL_KEY, 0);
    endtask

    task automatic test_extreme_values();
        send_request(CMD_INSERT, VAL_MIN);
        send_request(CMD_INSERT, VAL_MAX);
        send_request(CMD_INSERT, 0);
        send_request(CMD_INSERT, -1);
        send_request(CMD_INSERT, 5);
        send_request(CMD_INSERT, 5);
        send_request(CMD_DEL_KEY, 5);
        // one bit off a stored value must not match
        send_request(CMD_DEL_KEY, -2);
        send_request(CMD_DEL_HEAD, 0);
        send_request(CMD_DEL_TAIL, 0);
    endtask

    task automatic test_full_list();
        int fill;
        fill = DEPTH - list_model.size();
        for (int i = 0; i < fill; i++)
            send_request(CMD_INSERT, VAL_W'(i * 32'h1111_1111));
        send_request(CMD_INSERT, 42);
        send_request(CMD_DEL_KEY, VAL_W'(3 * 32'h1111_1111));
    endtask

    task automatic test_random_traffic(input int n);
        int bias;
        for (int i = 0; i < n; i++) begin
            // alternate filling, draining and balanced phases
            case ((i / 100) % 3)
                0:       bias = 70;
                1:       bias = 25;
                default: bias = 50;
            endcase
            send_random_request(bias);
        end
    endtask

    task automatic test_output_backpressure();
        hold_req = 60;
        idle_on  = 1'b0;
        for (int i = 0; i < 40; i++) send_random_request(50);
        idle_on  = 1'b1;
    endtask

    task automatic test_drain_pauses();
        for (int i = 0; i < 10; i++) begin
            for (int j = 0; j < 20; j++) send_random_request(55);
            wait_until_drained();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_traffic(300);
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.command = CMD_INSERT;
        req_if.value   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_extreme_values();
        test_full_list();
        test_random_traffic(700);
        test_output_backpressure();
        test_drain_pauses();
        test_back_to_back();
        test_random_traffic(700);

        wait_until_drained();
        repeat (10) @(posedge i_clk);

        $display("%0d requests, %0d results checked over %0d cycles",
                 sent_cnt, result_cnt, cycle_cnt);
        $display("status seen: ok %0d, empty %0d, not found %0d, full %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY],
                 status_hits[ST_NOT_FOUND], status_hits[ST_FULL]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
